@@ src/ffa_pkg.sv @@
// Shared types and constants of the first-fit extent allocator.
// Holds the request/result payloads, the extent record, the controller
// states and the controller-to-datapath command and status groups.
package ffa_pkg;

    localparam int DEF_MAX_EXTENTS = 64;
    localparam int ALIGN_BYTES     = 16;
    localparam int MIN_BLOCK       = 16;
    localparam int HDR_BYTES       = 8;

    localparam logic [63:0] RESET_BASE  = 64'hFFFF_8100_0000_0000;
    localparam logic [32:0] RESET_BYTES = 33'd1048576;
    localparam logic [32:0] HEAP_LIMIT  = 33'h1_0000_0000;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ZERO_REQ  = 3'd1;
    localparam logic [2:0] ST_NO_MEM    = 3'd2;
    localparam logic [2:0] ST_BAD_FREE  = 3'd3;
    localparam logic [2:0] ST_TBL_FULL  = 3'd4;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic CFG_HEAP_BASE  = 1'b0;
    localparam logic CFG_HEAP_BYTES = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [31:0] req_size;
        logic [63:0] user_addr;
        logic [63:0] header_size;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] granted_addr;
        logic [32:0] granted_bytes;
    } rsp_t;

    typedef struct packed {
        logic [31:0] off;
        logic [32:0] len;
    } ext_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_INIT,
        OP_ACCEPT,
        OP_FCHK1,
        OP_FCHK2,
        OP_READ_IDX,
        OP_ADVANCE,
        OP_ALLOC_TAKE,
        OP_FREE_EVAL,
        OP_SCAN_END,
        OP_FREE_MERGE,
        OP_INS_START,
        OP_RM_READ,
        OP_RM_WRITE,
        OP_RM_DONE,
        OP_INS_READ,
        OP_INS_WRITE,
        OP_INS_DONE,
        OP_FAIL_ZERO,
        OP_FAIL_OOM,
        OP_FAIL_INV,
        OP_FAIL_FULL,
        OP_PUBLISH
    } dp_op_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_FCHK2,
        S_FCHECK,
        S_SCAN_RD,
        S_SCAN_EV,
        S_FREE_DEC,
        S_RM_RD,
        S_RM_WR,
        S_INS_RD,
        S_INS_WR,
        S_DONE
    } state_t;

    typedef struct packed {
        dp_op_t op;
        logic   idle;
    } ctl_cmd_t;

    typedef struct packed {
        logic is_free;
        logic req_zero;
        logic chk_bad;
        logic idx_end;
        logic fit;
        logic split;
        logic precedes;
        logic overlap;
        logic join_prev;
        logic join_next;
        logic full;
        logic rm_end;
        logic ins_end;
        logic out_free;
    } dp_stat_t;

endpackage

@@ src/first_fit_extent_allocator.sv @@
// First-fit extent allocator with coalescing on free.
// Channels: in_valid/in_stall/in_data carry one allocate or free request,
// out_valid/out_stall/out_data return exactly one result per request.
// The cfg port writes heap_base (index 0) or heap_bytes (index 1); a
// heap_bytes write rebuilds the free table as one extent. Write it only
// while no request is in flight.
// Requests are handled one at a time: setup, an address-ordered scan of
// the extents, and entry moves when the table grows or shrinks, all
// through the single-port extent table RAM. in_stall is low only while
// the block is idle.
// The result sits in an output register; the block accepts the next request
// while it waits, and holds a finished result while out_stall is high.
// After reset the S_INIT state writes the single initial extent, during which
// in_stall stays high. Depends on ffa_pkg, ffa_ctrl and ffa_datapath.
module first_fit_extent_allocator #(
    parameter int MAX_EXTENTS = ffa_pkg::DEF_MAX_EXTENTS
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  ffa_pkg::req_t in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output ffa_pkg::rsp_t out_data,
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic [63:0]   cfg_wdata
);
    import ffa_pkg::*;

    ctl_cmd_t cmd;
    dp_stat_t stat;

    ffa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .stat     (stat),
        .cmd      (cmd)
    );

    ffa_datapath #(
        .MAX_EXTENTS (MAX_EXTENTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_stall (out_stall),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    assign in_stall = !cmd.idle;

`ifndef ASSERT_OFF
    // Only one request is in flight: an accepted request closes the input.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted while a request is in flight");

    // Failed requests report no address and no size.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.status != ST_OK))
            |-> ((out_data.granted_addr == 64'd0) && (out_data.granted_bytes == 33'd0)))
        else $error("error result carries a grant");

    // Any granted block is at least the minimum block size.
    a_grant_min: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.status == ST_OK) && (out_data.granted_bytes != 33'd0))
            |-> (out_data.granted_bytes >= 33'(MIN_BLOCK)))
        else $error("grant below minimum block size");
`endif

endmodule

@@ src/ffa_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependencies.
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/ffa_ctrl.sv @@
// Sequencing state machine of the extent allocator.
// Depends on ffa_pkg; drives datapath commands from datapath status.
module ffa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  ffa_pkg::dp_stat_t  stat,
    output ffa_pkg::ctl_cmd_t  cmd
);
    import ffa_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        cmd.idle   = 1'b0;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.op     = OP_INIT;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                cmd.idle = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_ACCEPT;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.is_free)
                begin
                    cmd.op     = OP_FCHK1;
                    state_next = S_FCHK2;
                end
                else if (stat.req_zero)
                begin
                    cmd.op     = OP_FAIL_ZERO;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_FCHK2:
            begin
                cmd.op     = OP_FCHK2;
                state_next = S_FCHECK;
            end
            S_FCHECK:
            begin
                if (stat.chk_bad)
                begin
                    cmd.op     = OP_FAIL_INV;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                if (stat.idx_end)
                begin
                    if (stat.is_free)
                    begin
                        cmd.op     = OP_SCAN_END;
                        state_next = S_FREE_DEC;
                    end
                    else
                    begin
                        cmd.op     = OP_FAIL_OOM;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    cmd.op     = OP_READ_IDX;
                    state_next = S_SCAN_EV;
                end
            end
            S_SCAN_EV:
            begin
                if (stat.is_free)
                begin
                    cmd.op     = OP_FREE_EVAL;
                    state_next = stat.precedes ? S_SCAN_RD : S_FREE_DEC;
                end
                else if (stat.fit)
                begin
                    cmd.op     = OP_ALLOC_TAKE;
                    state_next = stat.split ? S_DONE : S_RM_RD;
                end
                else
                begin
                    cmd.op     = OP_ADVANCE;
                    state_next = S_SCAN_RD;
                end
            end
            S_FREE_DEC:
            begin
                if (stat.overlap)
                begin
                    cmd.op     = OP_FAIL_INV;
                    state_next = S_DONE;
                end
                else if (stat.join_prev && stat.join_next)
                begin
                    // The merged extent absorbs its right neighbor, which is then removed.
                    cmd.op     = OP_FREE_MERGE;
                    state_next = S_RM_RD;
                end
                else if (stat.join_prev || stat.join_next)
                begin
                    cmd.op     = OP_FREE_MERGE;
                    state_next = S_DONE;
                end
                else if (stat.full)
                begin
                    cmd.op     = OP_FAIL_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_INS_START;
                    state_next = S_INS_RD;
                end
            end
            S_RM_RD:
            begin
                if (stat.rm_end)
                begin
                    cmd.op     = OP_RM_DONE;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_RM_READ;
                    state_next = S_RM_WR;
                end
            end
            S_RM_WR:
            begin
                cmd.op     = OP_RM_WRITE;
                state_next = S_RM_RD;
            end
            S_INS_RD:
            begin
                if (stat.ins_end)
                begin
                    cmd.op     = OP_INS_DONE;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_INS_READ;
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR:
            begin
                cmd.op     = OP_INS_WRITE;
                state_next = S_INS_RD;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_PUBLISH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ src/ffa_datapath.sv @@
// Datapath of the extent allocator: configuration, extent table RAM,
// scan and shift registers, result and output registers.
// Depends on ffa_pkg and ffa_ram.
module ffa_datapath #(
    parameter int MAX_EXTENTS = ffa_pkg::DEF_MAX_EXTENTS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ffa_pkg::req_t      in_data,
    input  logic               out_stall,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [63:0]        cfg_wdata,
    input  ffa_pkg::ctl_cmd_t  cmd,
    output ffa_pkg::dp_stat_t  stat,
    output logic               out_valid,
    output ffa_pkg::rsp_t      out_data
);
    import ffa_pkg::*;

    localparam int IDX_W = $clog2(MAX_EXTENTS);
    localparam int CNT_W = $clog2(MAX_EXTENTS + 1);
    localparam int EXT_W = $bits(ext_t);
    localparam logic [33:0] ALIGN_MASK = 34'(ALIGN_BYTES - 1);
    localparam logic [33:0] ROUND_ADD  = 34'(HDR_BYTES + ALIGN_BYTES - 1);

    logic [63:0]      base_reg, base_next;
    logic [32:0]      hb_reg, hb_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] k_reg, k_next;
    req_t             req_reg, req_next;
    logic [63:0]      start_reg, start_next;
    logic [63:0]      off_reg, off_next;
    logic             below_reg, below_next;
    logic [33:0]      total_reg, total_next;
    logic             chk_bad_reg, chk_bad_next;
    logic [31:0]      foff_reg, foff_next;
    logic [32:0]      fsize_reg, fsize_next;
    logic [32:0]      fend_reg, fend_next;
    logic             prev_valid_reg, prev_valid_next;
    ext_t             prev_reg, prev_next;
    logic             cur_valid_reg, cur_valid_next;
    ext_t             cur_reg, cur_next;
    rsp_t             res_reg, res_next;
    rsp_t             out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [IDX_W-1:0] ram_raddr;
    logic [EXT_W-1:0] ram_wdata;
    logic [EXT_W-1:0] ram_rdata;
    ext_t             ent;
    ext_t             wr_ent;

    logic [33:0]      rem;
    logic [33:0]      prev_end;
    logic [CNT_W-1:0] idx_p1;
    logic [CNT_W-1:0] idx_m1;
    logic [CNT_W-1:0] k_m1;
    logic [32:0]      hb_sat;
    logic             join_prev;
    logic             join_next;

    ffa_ram #(
        .WIDTH (EXT_W),
        .DEPTH (MAX_EXTENTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ent       = ext_t'(ram_rdata);
    assign ram_wdata = wr_ent;

    assign rem      = {1'b0, ent.len} - total_reg;
    assign prev_end = {2'b00, prev_reg.off} + {1'b0, prev_reg.len};
    assign idx_p1   = idx_reg + 1'b1;
    assign idx_m1   = idx_reg - 1'b1;
    assign k_m1     = k_reg - 1'b1;
    assign hb_sat   = (cfg_wdata[32:0] > HEAP_LIMIT) ? HEAP_LIMIT : cfg_wdata[32:0];

    assign join_prev = prev_valid_reg && (prev_end == {2'b00, foff_reg});
    assign join_next = cur_valid_reg && ({1'b0, cur_reg.off} == fend_reg);

    always_comb
    begin
        stat.is_free   = (req_reg.cmd == CMD_FREE);
        stat.req_zero  = (req_reg.req_size == 32'd0);
        stat.chk_bad   = chk_bad_reg;
        stat.idx_end   = (idx_reg >= count_reg);
        stat.fit       = ({1'b0, ent.len} >= total_reg);
        stat.split     = (rem >= 34'(MIN_BLOCK));
        stat.precedes  = (ent.off < foff_reg);
        stat.overlap   = (prev_valid_reg && (prev_end > {2'b00, foff_reg}))
                      || (cur_valid_reg && (fend_reg > {1'b0, cur_reg.off}));
        stat.join_prev = join_prev;
        stat.join_next = join_next;
        stat.full      = (count_reg == CNT_W'(MAX_EXTENTS));
        stat.rm_end    = ({1'b0, idx_p1} >= {1'b0, count_reg}) || (idx_p1 == '0);
        stat.ins_end   = (k_reg == idx_reg);
        stat.out_free  = !out_valid_reg || !out_stall;
    end

    // Table write and read port control.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg[IDX_W-1:0];
        ram_raddr = idx_reg[IDX_W-1:0];
        wr_ent    = ent;
        case (cmd.op)
            OP_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                wr_ent    = '{off: 32'd0, len: hb_reg};
            end
            OP_ALLOC_TAKE:
            begin
                ram_we = stat.split;
                wr_ent = '{off: ent.off + total_reg[31:0], len: rem[32:0]};
            end
            OP_FREE_MERGE:
            begin
                ram_we = 1'b1;
                if (join_prev)
                begin
                    ram_waddr = idx_m1[IDX_W-1:0];
                    wr_ent.off = prev_reg.off;
                    wr_ent.len = join_next ? (prev_reg.len + fsize_reg + cur_reg.len)
                                           : (prev_reg.len + fsize_reg);
                end
                else
                begin
                    wr_ent = '{off: foff_reg, len: cur_reg.len + fsize_reg};
                end
            end
            OP_RM_READ:
            begin
                ram_raddr = idx_p1[IDX_W-1:0];
            end
            OP_RM_WRITE:
            begin
                ram_we = 1'b1;
            end
            OP_INS_READ:
            begin
                ram_raddr = k_m1[IDX_W-1:0];
            end
            OP_INS_WRITE:
            begin
                ram_we    = 1'b1;
                ram_waddr = k_reg[IDX_W-1:0];
            end
            OP_INS_DONE:
            begin
                ram_we = 1'b1;
                wr_ent = '{off: foff_reg, len: fsize_reg};
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
        // A heap length write rebuilds the table as one extent.
        if (cfg_we && (cfg_index == CFG_HEAP_BYTES))
        begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            wr_ent    = '{off: 32'd0, len: hb_sat};
        end
    end

    always_comb
    begin
        base_next       = base_reg;
        hb_next         = hb_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        k_next          = k_reg;
        req_next        = req_reg;
        start_next      = start_reg;
        off_next        = off_reg;
        below_next      = below_reg;
        total_next      = total_reg;
        chk_bad_next    = chk_bad_reg;
        foff_next       = foff_reg;
        fsize_next      = fsize_reg;
        fend_next       = fend_reg;
        prev_valid_next = prev_valid_reg;
        prev_next       = prev_reg;
        cur_valid_next  = cur_valid_reg;
        cur_next        = cur_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && out_stall;

        case (cmd.op)
            OP_ACCEPT:
            begin
                req_next        = in_data;
                start_next      = in_data.user_addr - 64'(HDR_BYTES);
                total_next      = ({2'b00, in_data.req_size} + ROUND_ADD) & ~ALIGN_MASK;
                idx_next        = '0;
                prev_valid_next = 1'b0;
                cur_valid_next  = 1'b0;
            end
            OP_FCHK1:
            begin
                off_next   = start_reg - base_reg;
                below_next = (start_reg < base_reg);
            end
            OP_FCHK2:
            begin
                chk_bad_next = below_reg
                            || (off_reg >= {31'd0, hb_reg})
                            || (req_reg.header_size < 64'(MIN_BLOCK))
                            || ((start_reg & 64'(ALIGN_BYTES - 1)) != 64'd0)
                            || (req_reg.header_size > ({31'd0, hb_reg} - off_reg));
                foff_next  = off_reg[31:0];
                fsize_next = req_reg.header_size[32:0];
                fend_next  = {1'b0, off_reg[31:0]} + req_reg.header_size[32:0];
            end
            OP_ADVANCE:
            begin
                idx_next = idx_p1;
            end
            OP_ALLOC_TAKE:
            begin
                res_next.status        = ST_OK;
                res_next.granted_addr  = base_reg + {32'd0, ent.off} + 64'(HDR_BYTES);
                res_next.granted_bytes = stat.split ? total_reg[32:0] : ent.len;
            end
            OP_FREE_EVAL:
            begin
                if (stat.precedes)
                begin
                    prev_next       = ent;
                    prev_valid_next = 1'b1;
                    idx_next        = idx_p1;
                end
                else
                begin
                    cur_next       = ent;
                    cur_valid_next = 1'b1;
                end
            end
            OP_SCAN_END:
            begin
                cur_valid_next = 1'b0;
            end
            OP_FREE_MERGE:
            begin
                res_next = '{status: ST_OK, granted_addr: 64'd0, granted_bytes: 33'd0};
            end
            OP_INS_START:
            begin
                k_next = count_reg;
            end
            OP_RM_WRITE:
            begin
                idx_next = idx_p1;
            end
            OP_RM_DONE:
            begin
                count_next = count_reg - 1'b1;
            end
            OP_INS_WRITE:
            begin
                k_next = k_m1;
            end
            OP_INS_DONE:
            begin
                count_next = count_reg + 1'b1;
                res_next   = '{status: ST_OK, granted_addr: 64'd0, granted_bytes: 33'd0};
            end
            OP_FAIL_ZERO:
            begin
                res_next = '{status: ST_ZERO_REQ, granted_addr: 64'd0, granted_bytes: 33'd0};
            end
            OP_FAIL_OOM:
            begin
                res_next = '{status: ST_NO_MEM, granted_addr: 64'd0, granted_bytes: 33'd0};
            end
            OP_FAIL_INV:
            begin
                res_next = '{status: ST_BAD_FREE, granted_addr: 64'd0, granted_bytes: 33'd0};
            end
            OP_FAIL_FULL:
            begin
                res_next = '{status: ST_TBL_FULL, granted_addr: 64'd0, granted_bytes: 33'd0};
            end
            OP_PUBLISH:
            begin
                out_next       = res_reg;
                out_valid_next = 1'b1;
            end
            default:
            begin
                out_next = out_reg;
            end
        endcase

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HEAP_BASE:
                begin
                    base_next = cfg_wdata;
                end
                CFG_HEAP_BYTES:
                begin
                    hb_next    = hb_sat;
                    count_next = (hb_sat >= 33'(MIN_BLOCK)) ? CNT_W'(1) : '0;
                end
                default:
                begin
                    base_next = base_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg       <= RESET_BASE;
            hb_reg         <= RESET_BYTES;
            count_reg      <= CNT_W'(1);
            idx_reg        <= '0;
            k_reg          <= '0;
            prev_valid_reg <= 1'b0;
            cur_valid_reg  <= 1'b0;
            chk_bad_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            base_reg       <= base_next;
            hb_reg         <= hb_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            k_reg          <= k_next;
            prev_valid_reg <= prev_valid_next;
            cur_valid_reg  <= cur_valid_next;
            chk_bad_reg    <= chk_bad_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        start_reg <= start_next;
        off_reg   <= off_next;
        below_reg <= below_next;
        total_reg <= total_next;
        foff_reg  <= foff_next;
        fsize_reg <= fsize_next;
        fend_reg  <= fend_next;
        prev_reg  <= prev_next;
        cur_reg   <= cur_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
